FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the median selector.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mbrms_pkg.sv
// Types and constants for the median selector.
// No dependencies; used by the top level.
`default_nettype none

package mbrms_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned RANK_SIZE_W = 9;
  localparam int unsigned RANK_W      = RANK_SIZE_W - 1;

  // Reported when a pass finds nothing above the previous pick.
  localparam logic signed [DATA_W-1:0] NONE_LEFT = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/mbrms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mbrms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/median_by_repeated_min_selection.sv
// Median selector: stores a list, then finds the distinct value at rank size/2.
// Depends on mbrms_pkg, mbrms_ram and assert_macros.svh.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   in      | input     | in_valid_i / in_stall_o  | value_i, last_i, rank_size_i
//   out     | output    | out_valid_o / out_stall_i| median_o
//
// List elements are taken at one per cycle while loading. After the last element
// is taken, with N stored entries and rank r = rank_size/2, the search reads
// one store entry per cycle through the single RAM read port in each pass, with
// one pass per rank step, fewer passes when the distinct values run out.
// in_stall_o is high for the whole search, and stays high while the finished
// result waits for a previous one still held in the output register by out_stall_i.
// Reset is asynchronous and clears control only; the store needs no clearing,
// as only entries below the fill count are read.
`default_nettype none
`include "assert_macros.svh"

module median_by_repeated_min_selection #(
  parameter int unsigned MAX_ITEMS = 256
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     in_valid_i,
  output logic                                          in_stall_o,
  input  wire logic signed [mbrms_pkg::DATA_W-1:0]      value_i,
  input  wire logic                                     last_i,
  input  wire logic        [mbrms_pkg::RANK_SIZE_W-1:0] rank_size_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_stall_i,
  output logic signed [mbrms_pkg::DATA_W-1:0]           median_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);

  mbrms_pkg::state_e state_q, state_d;

  // Control state
  logic [CNT_W-1:0]             cnt_q, cnt_d;         // stored entries
  logic [CNT_W-1:0]             rd_idx_q, rd_idx_d;   // next entry to read in a pass
  logic                         rd_vld_q, rd_vld_d;   // read data arrives this cycle
  logic                         found_q, found_d;     // pass has a candidate
  logic [mbrms_pkg::RANK_W-1:0] pass_q, pass_d;
  logic                         out_valid_q, out_valid_d;

  // Payload
  logic [mbrms_pkg::RANK_W-1:0]        rank_q, rank_d;
  logic signed [mbrms_pkg::DATA_W-1:0] best_q, best_d;  // running minimum of a pass
  logic signed [mbrms_pkg::DATA_W-1:0] thr_q, thr_d;    // previous pass's pick
  logic signed [mbrms_pkg::DATA_W-1:0] res_q, res_d;
  logic signed [mbrms_pkg::DATA_W-1:0] median_q, median_d;

  // Control decoded from the state
  logic                         in_acc;
  logic                         ram_we;
  logic                         ram_re;
  logic                         scan_end;
  logic                         eval_end;
  logic                         out_load;
  logic signed [mbrms_pkg::DATA_W-1:0] rd_data;
  logic                         eligible;

  // ---------------------------------------------------------------------------
  // Value store
  // ---------------------------------------------------------------------------
  mbrms_ram #(
    .WIDTH (mbrms_pkg::DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbrms_pkg::ST_LOAD: begin
        if (in_valid_i && last_i) begin
          state_d = mbrms_pkg::ST_SCAN;
        end
      end
      mbrms_pkg::ST_SCAN: begin
        if (rd_idx_q == cnt_q && !rd_vld_q) begin
          state_d = mbrms_pkg::ST_EVAL;
        end
      end
      mbrms_pkg::ST_EVAL: begin
        if (!found_q || pass_q == rank_q) begin
          state_d = mbrms_pkg::ST_DONE;
        end else begin
          state_d = mbrms_pkg::ST_SCAN;
        end
      end
      mbrms_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = mbrms_pkg::ST_LOAD;
        end
      end
      default: state_d = mbrms_pkg::ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    scan_end   = 1'b0;
    eval_end   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      mbrms_pkg::ST_LOAD: in_stall_o = 1'b0;
      mbrms_pkg::ST_SCAN: begin
        ram_re   = (rd_idx_q < cnt_q);
        scan_end = (rd_idx_q == cnt_q) && !rd_vld_q;
      end
      mbrms_pkg::ST_EVAL: eval_end = !found_q || (pass_q == rank_q);
      mbrms_pkg::ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  // Accept only while loading; drop elements once the store is full.
  assign in_acc = in_valid_i && !in_stall_o;
  assign ram_we = in_acc && (cnt_q < CNT_MAX);

  // The first pass takes the plain minimum; later ones only values above the pick.
  assign eligible = (pass_q == '0) || (rd_data > thr_q);

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_d    = cnt_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    found_d  = found_q;
    pass_d   = pass_q;
    rank_d   = rank_q;
    best_d   = best_q;
    thr_d    = thr_q;
    res_d    = res_q;

    if (ram_we) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (in_acc && last_i) begin
      // Start the first pass over the list, including this element.
      rank_d   = rank_size_i[mbrms_pkg::RANK_SIZE_W-1:1];
      pass_d   = '0;
      rd_idx_d = '0;
      found_d  = 1'b0;
    end

    if (ram_re) begin
      rd_idx_d = rd_idx_q + 1'b1;
      rd_vld_d = 1'b1;
    end
    if (rd_vld_q && eligible && (!found_q || rd_data < best_q)) begin
      best_d  = rd_data;
      found_d = 1'b1;
    end

    if (state_q == mbrms_pkg::ST_EVAL) begin
      if (!found_q) begin
        res_d = mbrms_pkg::NONE_LEFT;
      end else if (eval_end) begin
        res_d = best_q;
      end else begin
        // Advance to the next pass above the current pick.
        thr_d    = best_q;
        pass_d   = pass_q + 1'b1;
        rd_idx_d = '0;
        found_d  = 1'b0;
      end
    end

    // Hand the result over and clear the list for the next one.
    if (out_load) begin
      cnt_d = '0;
    end
  end

  // Output register: hold while stalled, load from the search result.
  always_comb begin
    out_valid_d = out_load || (out_valid_q && out_stall_i);
    median_d    = out_load ? res_q : median_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbrms_pkg::ST_LOAD;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q   <= rank_d;
    best_q   <= best_d;
    thr_q    <= thr_d;
    res_q    <= res_d;
    median_q <= median_d;
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMP(a_rose_after_done, $rose(out_valid_q), $past(state_q) == mbrms_pkg::ST_DONE,
              "result appeared without a finished search")
  `ASSERT_IMP(a_no_write_in_search, ram_we, state_q == mbrms_pkg::ST_LOAD,
              "store written during a search")
  `ASSERT_IMP(a_read_data_in_scan, rd_vld_q, $past(state_q) == mbrms_pkg::ST_SCAN,
              "read data without a read issued in a pass")
  `ASSERT_NXT(a_list_cleared, out_load, cnt_q == '0 && state_q == mbrms_pkg::ST_LOAD,
              "list not cleared after result hand-over")
  `ASSERT_IMP(a_pass_in_range, state_q == mbrms_pkg::ST_SCAN, pass_q <= rank_q,
              "pass index beyond rank")
  `ASSERT_IMP(a_scan_end_drained, scan_end, !ram_re && !rd_vld_q,
              "pass ended with reads in flight")

endmodule

`default_nettype wire
